>>> src/adc7seg_pkg.sv
// Shared constants, widths and the seven-segment digit table for the converter display core.
// Has no dependencies. The core takes it in through a wildcard import.
`default_nettype none

package adc7seg_pkg;

    // Sample path
    localparam int SAMPLE_BITS = 12;
    localparam int AVG_LOG2    = 3;
    localparam int SUM_W       = SAMPLE_BITS + AVG_LOG2;
    localparam int CNT_W       = AVG_LOG2;
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    // Millivolt scaling: v = avg * 806 / 1000 = ((avg * 806) >> 3) / 125
    localparam int              MV_NUM_W     = 10;
    localparam logic [MV_NUM_W-1:0] MV_NUM   = 10'd806;
    localparam int              PROD_W       = SAMPLE_BITS + MV_NUM_W;
    localparam int              MV_PRE_SHIFT = 3;
    localparam int              RECIP_W      = 20;
    // ceil(2^26 / 125); exact floor quotient for every dividend below 2^22
    localparam logic [RECIP_W-1:0] RECIP_125 = 20'd536871;
    localparam int              RECIP_SHIFT  = 26;
    localparam int              MVX_W        = PROD_W - MV_PRE_SHIFT;
    localparam int              MVF_W        = MVX_W + RECIP_W;

    // Decimal split of a clamped value (0..9999)
    localparam int              DV_W       = 14;
    localparam logic [DV_W-1:0] DV_MAX     = 14'd9999;
    localparam int              Q1000_W    = 4;
    localparam int              Q100_W     = 7;
    localparam int              Q10_W      = 10;
    // ceil(2^k / d) magics, exact for every value up to 9999
    localparam logic [14:0]     RECIP_1000 = 15'd16778;
    localparam int              SH_1000    = 24;
    localparam logic [13:0]     RECIP_100  = 14'd10486;
    localparam int              SH_100     = 20;
    localparam logic [12:0]     RECIP_10   = 13'd6554;
    localparam int              SH_10      = 16;

    // Output
    localparam int SEG_W       = 8;
    localparam int SHOWN_W     = 12;
    localparam int OUT_FIELD_W = 4 * SEG_W + SHOWN_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [SEG_W-1:0] SEG_A  = 8'h80;
    localparam logic [SEG_W-1:0] SEG_B  = 8'h40;
    localparam logic [SEG_W-1:0] SEG_C  = 8'h20;
    localparam logic [SEG_W-1:0] SEG_DP = 8'h10;
    localparam logic [SEG_W-1:0] SEG_F  = 8'h08;
    localparam logic [SEG_W-1:0] SEG_G  = 8'h04;
    localparam logic [SEG_W-1:0] SEG_E  = 8'h02;
    localparam logic [SEG_W-1:0] SEG_D  = 8'h01;

    localparam logic MODE_COUNT    = 1'b0;
    localparam logic MODE_MILLIVOLT = 1'b1;

    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        case (digit)
            4'd0:    code = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    code = SEG_B | SEG_C;
            4'd2:    code = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    code = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    code = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5:    code = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6:    code = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7:    code = SEG_A | SEG_B | SEG_C;
            4'd8:    code = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    code = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> src/adc_average_seven_segment_core.sv
// Block averager and seven-segment display encoder for 12-bit converter samples.
// Depends on adc7seg_pkg (widths, scaling constants, digit table).
`default_nettype none

// Every accepted sample is added into a block sum; each eighth sample updates the
// held average (sum >> 3). Each sample yields one transfer with four segment codes
// and the shown value, which is the held average (count mode) or
// average*806/1000 truncated, with the hundreds dp lit (millivolt mode, reset default).
// Throughput is one sample per cycle unless every stage is full while m_tready is low.
// m_tvalid rises once a sample has passed the five register stages: state update, the
// 806 product, the reciprocal divide by 1000, the decimal quotients, and the segment
// output register. Each stage advances independently, so inputs keep flowing into
// empty stages while a result waits on m_tready. display_mode is written through
// cfg_wr_en/cfg_wr_data.
module adc_average_seven_segment_core (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic                                  cfg_wr_data,   // display_mode
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [adc7seg_pkg::IN_TDATA_W-1:0]    s_tdata,       // [11:0] sample
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // [7:0] seg_thousands, [15:8] seg_hundreds, [23:16] seg_tens,
    // [31:24] seg_ones, [43:32] shown_value, rest zero
    output logic [adc7seg_pkg::OUT_TDATA_W-1:0]        m_tdata
);
    import adc7seg_pkg::*;

    logic                   mode_reg;
    logic [SUM_W-1:0]       block_sum_reg, block_sum_next;
    logic [CNT_W-1:0]       block_count_reg, block_count_next;
    logic [SAMPLE_BITS-1:0] held_avg_reg, held_avg_next;

    // stage 1: updated average
    logic                   v1_reg;
    logic                   mode1_reg;
    logic [SAMPLE_BITS-1:0] avg1_reg;
    // stage 2: scaled product
    logic                   v2_reg;
    logic                   mode2_reg;
    logic [SAMPLE_BITS-1:0] avg2_reg;
    logic [PROD_W-1:0]      prod2_reg;
    // stage 3: shown value
    logic                   v3_reg;
    logic                   mode3_reg;
    logic [SAMPLE_BITS-1:0] val3_reg, val3_next;
    // stage 4: decimal quotients
    logic                   v4_reg;
    logic                   mode4_reg;
    logic [SAMPLE_BITS-1:0] val4_reg;
    logic [DV_W-1:0]        dv4_reg;
    logic [Q1000_W-1:0]     q1000_reg, q1000_next;
    logic [Q100_W-1:0]      q100_reg, q100_next;
    logic [Q10_W-1:0]       q10_reg, q10_next;
    // output register
    logic                   out_v_reg;
    logic [SEG_W-1:0]       seg_th_reg, seg_hd_reg, seg_tn_reg, seg_on_reg;
    logic [SEG_W-1:0]       seg_th_next, seg_hd_next, seg_tn_next, seg_on_next;
    logic [SHOWN_W-1:0]     shown_reg;

    logic free_out, free4, free3, free2, free1;
    logic s_fire;

    logic [SAMPLE_BITS-1:0] sample;
    logic [SUM_W-1:0]       sum_add;

    logic [MVX_W-1:0]       mv_x;
    logic [MVF_W-1:0]       mv_full;

    logic [DV_W-1:0]        dv;
    logic [28:0]            p1000;
    logic [27:0]            p100;
    logic [26:0]            p10;

    logic [Q100_W-1:0]      hd_diff;
    logic [Q10_W-1:0]       tn_diff;
    logic [DV_W-1:0]        on_diff;

    // Per-stage flow control: a stage loads when empty or when its content moves on
    assign free_out = !out_v_reg || m_tready;
    assign free4    = !v4_reg || free_out;
    assign free3    = !v3_reg || free4;
    assign free2    = !v2_reg || free3;
    assign free1    = !v1_reg || free2;
    assign s_tready = free1;
    assign s_fire   = s_tvalid && s_tready;

    // Block accumulation
    always_comb begin
        sample           = s_tdata[SAMPLE_BITS-1:0];
        sum_add          = block_sum_reg + SUM_W'(sample);
        block_sum_next   = sum_add;
        block_count_next = block_count_reg + CNT_W'(1);
        held_avg_next    = held_avg_reg;
        if (block_count_reg == {CNT_W{1'b1}}) begin
            held_avg_next    = sum_add[SUM_W-1 -: SAMPLE_BITS];
            block_sum_next   = '0;
            block_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_MILLIVOLT;
            block_sum_reg   <= '0;
            block_count_reg <= '0;
            held_avg_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                block_sum_reg   <= block_sum_next;
                block_count_reg <= block_count_next;
                held_avg_reg    <= held_avg_next;
            end
        end
    end

    // Stage 3 math: exact divide by 1000 as >>3 then reciprocal of 125
    always_comb begin
        mv_x    = prod2_reg[PROD_W-1:MV_PRE_SHIFT];
        mv_full = MVF_W'(mv_x) * MVF_W'(RECIP_125);
        if (mode2_reg == MODE_MILLIVOLT) begin
            val3_next = mv_full[RECIP_SHIFT +: SAMPLE_BITS];
        end else begin
            val3_next = avg2_reg;
        end
    end

    // Stage 4 math: clamp and parallel constant divides
    always_comb begin
        if (DV_W'(val3_reg) > DV_MAX) begin
            dv = DV_MAX;
        end else begin
            dv = DV_W'(val3_reg);
        end
        p1000      = 29'(dv) * 29'(RECIP_1000);
        p100       = 28'(dv) * 28'(RECIP_100);
        p10        = 27'(dv) * 27'(RECIP_10);
        q1000_next = p1000[SH_1000 +: Q1000_W];
        q100_next  = p100[SH_100 +: Q100_W];
        q10_next   = p10[SH_10 +: Q10_W];
    end

    // Output stage: digits by subtraction, then segment lookup
    always_comb begin
        hd_diff     = q100_reg - Q100_W'(q1000_reg) * Q100_W'(10);
        tn_diff     = q10_reg - Q10_W'(q100_reg) * Q10_W'(10);
        on_diff     = dv4_reg - DV_W'(q10_reg) * DV_W'(10);
        seg_th_next = seg_code(q1000_reg);
        seg_hd_next = seg_code(hd_diff[3:0]);
        if (mode4_reg == MODE_MILLIVOLT) begin
            seg_hd_next = seg_hd_next | SEG_DP;
        end
        seg_tn_next = seg_code(tn_diff[3:0]);
        seg_on_next = seg_code(on_diff[3:0]);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (free1) begin
                v1_reg <= s_fire;
            end
            if (free2) begin
                v2_reg <= v1_reg;
            end
            if (free3) begin
                v3_reg <= v2_reg;
            end
            if (free4) begin
                v4_reg <= v3_reg;
            end
            if (free_out) begin
                out_v_reg <= v4_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            avg1_reg  <= held_avg_next;
            mode1_reg <= mode_reg;
        end
        if (free2 && v1_reg) begin
            avg2_reg  <= avg1_reg;
            mode2_reg <= mode1_reg;
            prod2_reg <= PROD_W'(avg1_reg) * PROD_W'(MV_NUM);
        end
        if (free3 && v2_reg) begin
            val3_reg  <= val3_next;
            mode3_reg <= mode2_reg;
        end
        if (free4 && v3_reg) begin
            val4_reg  <= val3_reg;
            mode4_reg <= mode3_reg;
            dv4_reg   <= dv;
            q1000_reg <= q1000_next;
            q100_reg  <= q100_next;
            q10_reg   <= q10_next;
        end
        if (free_out && v4_reg) begin
            seg_th_reg <= seg_th_next;
            seg_hd_reg <= seg_hd_next;
            seg_tn_reg <= seg_tn_next;
            seg_on_reg <= seg_on_next;
            shown_reg  <= SHOWN_W'(val4_reg);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), shown_reg,
                       seg_on_reg, seg_tn_reg, seg_hd_reg, seg_th_reg};

`ifndef ASSERT_OFF
    // Closing a block clears the accumulator and the count
    a_block_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && block_count_reg == {CNT_W{1'b1}}
        |=> block_sum_reg == '0 && block_count_reg == '0)
        else $error("block sum/count not cleared at block end");

    // The average only moves when a block closes
    a_avg_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && block_count_reg == {CNT_W{1'b1}}) |=> $stable(held_avg_reg))
        else $error("held average changed inside a block");

    // Input is refused only when every stage is full and the output is stalled
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && v4_reg && out_v_reg && !m_tready)
        else $error("input stalled with a free stage");

    // The thousands digit never carries a decimal point
    a_no_dp_thousands: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SEG_W-1:0] & SEG_DP) == '0)
        else $error("dp set on thousands digit");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for adc_average_seven_segment_core: block average and segment display.
// Depends on adc7seg_pkg and the core; a predictor class checks every m_ transfer in order.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import adc7seg_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 267;
    localparam int RAND_PHASES    = 6;

    // Field layout of m_tdata, lowest bits last in the list
    typedef struct packed {
        logic [SHOWN_W-1:0] shown;
        logic [SEG_W-1:0]   ones;
        logic [SEG_W-1:0]   tens;
        logic [SEG_W-1:0]   hundreds;
        logic [SEG_W-1:0]   thousands;
    } display_t;

    class display_scoreboard;
        logic              mode;
        logic [SUM_W-1:0]  block_sum;
        logic [CNT_W-1:0]  block_count;
        logic [SAMPLE_BITS-1:0] held_avg;
        display_t          display_q[$];
        int unsigned       mismatches;

        function new();
            mode        = MODE_MILLIVOLT;
            block_sum   = '0;
            block_count = '0;
            held_avg    = '0;
            mismatches  = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function logic [SEG_W-1:0] digit_segments(int unsigned d);
            logic [SEG_W-1:0] segs;
            case (d)
                0: segs = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
                1: segs = SEG_B | SEG_C;
                2: segs = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
                3: segs = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
                4: segs = SEG_B | SEG_C | SEG_F | SEG_G;
                5: segs = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
                6: segs = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
                7: segs = SEG_A | SEG_B | SEG_C;
                8: segs = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
                default: segs = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            endcase
            return segs;
        endfunction

        // Accepted s_ transfer: advance the averager and queue the display it yields
        function void note_sample(logic [IN_TDATA_W-1:0] word);
            logic [SAMPLE_BITS-1:0] s;
            int unsigned v;
            int unsigned dv;
            display_t d;
            s = word[SAMPLE_BITS-1:0];
            block_sum   = block_sum + SUM_W'(s);
            block_count = block_count + 1'b1;
            // count wraps to zero on the eighth sample of a block
            if (block_count == '0) begin
                held_avg  = block_sum[SUM_W-1:AVG_LOG2];
                block_sum = '0;
            end
            v = 32'(held_avg);
            if (mode == MODE_MILLIVOLT) begin
                v = (v * 806) / 1000;
            end
            dv = (v > 9999) ? 9999 : v;
            d.thousands = digit_segments(dv / 1000);
            d.hundreds  = digit_segments((dv / 100) % 10);
            if (mode == MODE_MILLIVOLT) begin
                d.hundreds = d.hundreds | SEG_DP;
            end
            d.tens  = digit_segments((dv / 10) % 10);
            d.ones  = digit_segments(dv % 10);
            d.shown = v[SHOWN_W-1:0];
            display_q.push_back(d);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            display_t got;
            display_t want;
            bit ok;
            got = word[OUT_FIELD_W-1:0];
            if (display_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: %h", word);
                end
                return;
            end
            want = display_q.pop_front();
            ok = 1'b1;
            if (got.thousands != want.thousands) ok = 1'b0;
            if (got.hundreds  != want.hundreds)  ok = 1'b0;
            if (got.tens      != want.tens)      ok = 1'b0;
            if (got.ones      != want.ones)      ok = 1'b0;
            if (got.shown     != want.shown)     ok = 1'b0;
            if (!ok) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: thousands %h/%h hundreds %h/%h tens %h/%h",
                             want.thousands, got.thousands, want.hundreds, got.hundreds,
                             want.tens, got.tens);
                    $display("          ones %h/%h shown %0d/%0d (expected/actual)",
                             want.ones, got.ones, want.shown, got.shown);
                end
            end
        endfunction

        function int unsigned pending();
            return display_q.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic                   cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [11:0] sample
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [7:0] thousands, [15:8] hundreds, [23:16] tens,
                                       // [31:24] ones, [43:32] shown_value

    display_scoreboard sb;
    int send_idle_pct = 19;
    int recv_idle_pct = 45;
    int idle_cycles   = 0;

    adc_average_seven_segment_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitors read pre-edge values; every driver updates through NBAs
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_sample(s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_sample(input logic [IN_TDATA_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do begin
            @(posedge aclk);
        end while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_mode(input logic m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_mode(m);
    endtask

    task automatic send_random_phase(input int n);
        int style;
        int unsigned base;
        int unsigned s;
        logic [IN_TDATA_W-1:0] word;
        style = 0;
        base  = 0;
        for (int i = 0; i < n; i++) begin
            // new content style every eight samples so averages reach both ends
            if (i % 8 == 0) begin
                style = $urandom_range(0, 3);
                base  = $urandom_range(0, 4095);
            end
            case (style)
                0:       s = $urandom_range(0, 4095);
                1:       s = $urandom_range(4080, 4095);
                2:       s = $urandom_range(0, 15);
                default: s = base;
            endcase
            word = IN_TDATA_W'(s);
            if ($urandom_range(0, 3) == 0) begin
                word[IN_TDATA_W-1:SAMPLE_BITS] =
                    (IN_TDATA_W - SAMPLE_BITS)'($urandom_range(0, 15));
            end
            send_sample(word);
        end
    endtask

    initial begin
        int profile;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        sb = new();
        @(posedge aclk);
        @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Full-scale block in millivolt mode (reset default); padding bits must be ignored
        for (int i = 0; i < 8; i++) begin
            send_sample((i % 2 == 0) ? 16'hFFFF : 16'h0FFF);
        end
        // Zero block, padding set on a zero sample
        send_sample(16'hF000);
        for (int i = 0; i < 7; i++) begin
            send_sample(16'h0000);
        end
        drain_results();
        write_mode(MODE_COUNT);
        for (int i = 0; i < 8; i++) begin
            send_sample(16'h0FFF);
        end
        send_sample(16'h0001);
        send_sample(16'h0800);
        drain_results();

        for (int p = 0; p < RAND_PHASES; p++) begin
            profile = p / 2;
            case (profile)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_mode((p % 2 == 0) ? MODE_MILLIVOLT : MODE_COUNT);
            send_random_phase(PHASE_ITEMS);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
src/adc7seg_pkg.sv
src/adc_average_seven_segment_core.sv
bench/tb_top.sv
